// File: hw/rtl/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int unsigned CHAR_W = 8;

    localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;
    localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_RD,
        ST_DATA,
        ST_TERM
    } dnle_state_t;

    // One encoded output byte with its flags
    typedef struct packed {
        logic [CHAR_W-1:0] out_byte;
        logic              is_length;
        logic              name_end;
        logic              run_last;
    } dnle_out_t;

endpackage

// File: hw/rtl/dnle_ram.sv
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dnle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 63,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/dnle_out_reg.sv
// ----------------------------------------------------------------------------
// dnle_out_reg
// Output register stage: holds one encoded byte until the sink takes it.
// ----------------------------------------------------------------------------
module dnle_out_reg
    import dnle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  dnle_out_t load_data,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output dnle_out_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    dnle_out_t data_reg;

    // Slot is free when empty or being drained this cycle
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = (load && can_load) ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/dns_name_label_encoder.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Turns a dotted host name, one character per request, into DNS wire form.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                       Content
// s_axis    in   tvalid, tready, tdata[7:0]    name_char
// m_axis    out  tvalid, tready, tdata[7:0]    out_byte
//                tuser[1:0], tlast             tuser: is_length, name_end;
//                                              tlast: run_last
//
// A request that only stores a character writes it to the label RAM. A
// request that ends a label is accepted, loads the length byte, then for
// each stored character reads the label RAM and loads the output, and
// loads the terminator if the name ends there. A dropped character or a
// skipped dot is only accepted; a bare terminator is accepted and then
// loaded. rst_n clears the control state at once; the label RAM needs
// no clearing. Output stalls on m_axis hold the sequencer; the output
// register lets the next input request be taken while the final byte waits.
//
module dns_name_label_encoder
    import dnle_pkg::*;
#(
    parameter int unsigned LABEL_MAX = 63
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] name_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] is_length, [1] name_end
    output logic       m_axis_tlast    // run_last
);

    localparam int unsigned CNT_W  = $clog2(LABEL_MAX + 1);
    localparam int unsigned ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    dnle_state_t state_reg;
    dnle_state_t state_next;

    logic [CNT_W-1:0]  count_reg;        // characters held in the label RAM
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  len_reg;          // length of the label being emitted
    logic [CNT_W-1:0]  len_next;
    logic [ADDR_W-1:0] idx_reg;          // next label character to emit
    logic [ADDR_W-1:0] idx_next;
    logic              term_after_reg;   // emit terminator after the label
    logic              term_after_next;
    logic              full_reg;         // a full label was just emitted
    logic              full_next;
    logic              discard_reg;      // drop characters until end of name
    logic              discard_next;

    logic              in_fire;
    logic              is_nul;
    logic              is_dot;
    logic [CNT_W-1:0]  count_inc;
    logic              last_char;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [CHAR_W-1:0] ram_rd_data;

    logic              out_load;
    dnle_out_t         out_load_data;
    logic              out_can_load;
    dnle_out_t         out_data;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign is_nul    = (s_axis_tdata == NUL_CHAR);
    assign is_dot    = (s_axis_tdata == DOT_CHAR);
    assign count_inc = count_reg + CNT_W'(1);
    assign last_char = ((CNT_W'(idx_reg) + CNT_W'(1)) == len_reg);

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !discard_reg)
                begin
                    if (is_nul)
                    begin
                        state_next = (count_reg != '0) ? ST_LEN : ST_TERM;
                    end
                    else if (is_dot)
                    begin
                        if (!full_reg)
                        begin
                            state_next = (count_reg == '0) ? ST_TERM : ST_LEN;
                        end
                    end
                    else if (count_inc == CNT_W'(LABEL_MAX))
                    begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                if (out_can_load)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (out_can_load)
                begin
                    if (!last_char)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = term_after_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM:
            begin
                if (out_can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        out_load      = 1'b0;
        out_load_data = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                // Store a plain label character at the current count
                ram_wr_en = in_fire && !discard_reg && !is_nul && !is_dot;
            end
            ST_LEN:
            begin
                out_load                = 1'b1;
                out_load_data.out_byte  = CHAR_W'(len_reg);
                out_load_data.is_length = 1'b1;
            end
            ST_RD:
            begin
                ram_rd_en = 1'b1;
            end
            ST_DATA:
            begin
                out_load               = 1'b1;
                out_load_data.out_byte = ram_rd_data;
                out_load_data.run_last = last_char && !term_after_reg;
            end
            ST_TERM:
            begin
                out_load                = 1'b1;
                out_load_data.is_length = 1'b1;
                out_load_data.name_end  = 1'b1;
                out_load_data.run_last  = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Label bookkeeping
    // ------------------------------------------------------------------------
    always_comb
    begin
        count_next      = count_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        term_after_next = term_after_reg;
        full_next       = full_reg;
        discard_next    = discard_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (discard_reg)
                    begin
                        // Drop everything up to the end of the name
                        if (is_nul)
                        begin
                            discard_next = 1'b0;
                        end
                    end
                    else if (is_nul)
                    begin
                        len_next        = count_reg;
                        count_next      = '0;
                        term_after_next = 1'b1;
                        full_next       = 1'b0;
                    end
                    else if (is_dot)
                    begin
                        if (full_reg)
                        begin
                            full_next = 1'b0;
                        end
                        else if (count_reg == '0)
                        begin
                            discard_next = 1'b1;
                        end
                        else
                        begin
                            len_next        = count_reg;
                            count_next      = '0;
                            term_after_next = 1'b0;
                        end
                    end
                    else if (count_inc == CNT_W'(LABEL_MAX))
                    begin
                        // Label is full: flush it now
                        len_next        = count_inc;
                        count_next      = '0;
                        term_after_next = 1'b0;
                        full_next       = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                        full_next  = 1'b0;
                    end
                end
                idx_next = '0;
            end
            ST_DATA:
            begin
                if (out_can_load)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            len_reg        <= '0;
            idx_reg        <= '0;
            term_after_reg <= 1'b0;
            full_reg       <= 1'b0;
            discard_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            term_after_reg <= term_after_next;
            full_reg       <= full_next;
            discard_reg    <= discard_next;
        end
    end

    // ------------------------------------------------------------------------
    // Label store and output register
    // ------------------------------------------------------------------------
    dnle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LABEL_MAX),
        .AW    (ADDR_W)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    dnle_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_load_data),
        .can_load  (out_can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data.out_byte;
    assign m_axis_tuser = {out_data.name_end, out_data.is_length};
    assign m_axis_tlast = out_data.run_last;

endmodule

// File: dv/dnle_checker.sv
// ----------------------------------------------------------------------------
// dnle_checker
// Predicts and checks the wire-form bytes of the DNS name label encoder.
// ----------------------------------------------------------------------------
//
// Watches both stream channels. Every accepted input character is run
// through a label encoder model, and the bytes that it produces are queued.
// Every accepted output byte is compared field by field with the oldest
// queued byte. The count of queued bytes and of mismatches goes to the top.
//
module dnle_checker
    import dnle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,    // [7:0] name_char
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [7:0]        m_axis_tdata,    // [7:0] out_byte
    input  logic [1:0]        m_axis_tuser,    // [0] is_length, [1] name_end
    input  logic              m_axis_tlast,    // run_last
    output int unsigned       pending,
    output int unsigned       failures
);

    localparam int unsigned LABEL_MAX = 63;

    logic [CHAR_W-1:0] label_buf [LABEL_MAX];
    int unsigned       label_len;
    logic              skip_dot;
    logic              dropping;
    dnle_out_t         wire_bytes [$];
    dnle_out_t         burst [$];
    dnle_out_t         oldest;
    int unsigned       mismatch_count = 0;

    assign failures = mismatch_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void add_byte(input logic [7:0] b, input logic len_flag,
                                     input logic end_flag);
        dnle_out_t r;
        r.out_byte  = b;
        r.is_length = len_flag;
        r.name_end  = end_flag;
        r.run_last  = 1'b0;
        burst.push_back(r);
    endfunction

    // Length byte, then the held characters in order; the label starts over.
    function automatic void flush_label();
        add_byte(8'(label_len), 1'b1, 1'b0);
        for (int unsigned i = 0; i < label_len; i++)
            add_byte(label_buf[i], 1'b0, 1'b0);
        label_len = 0;
    endfunction

    function automatic void encode_char(input logic [7:0] c);
        dnle_out_t tail;
        burst.delete();
        if (dropping) begin
            if (c == NUL_CHAR)
                dropping = 1'b0;
        end else if (c == NUL_CHAR) begin
            if (label_len != 0)
                flush_label();
            add_byte(8'h00, 1'b1, 1'b1);
            skip_dot = 1'b0;
        end else if (c == DOT_CHAR) begin
            if (skip_dot) begin
                skip_dot = 1'b0;
            end else if (label_len == 0) begin
                // empty label: terminate now, drop the rest of the name
                add_byte(8'h00, 1'b1, 1'b1);
                dropping = 1'b1;
            end else begin
                flush_label();
            end
        end else begin
            skip_dot = 1'b0;
            label_buf[label_len] = c;
            label_len++;
            if (label_len == LABEL_MAX) begin
                flush_label();
                skip_dot = 1'b1;
            end
        end
        if (burst.size() != 0) begin
            tail = burst.pop_back();
            tail.run_last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[i])
            wire_bytes.push_back(burst[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wire_bytes.delete();
            label_len = 0;
            skip_dot  = 1'b0;
            dropping  = 1'b0;
            pending  <= 0;
        end
        else
        begin
            // check the output first: a byte leaving now never stems from
            // a character taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (wire_bytes.size() == 0)
                begin
                    report_mismatch("result with nothing expected",
                                    int'(m_axis_tdata), 0);
                end
                else
                begin
                    oldest = wire_bytes.pop_front();
                    if (m_axis_tdata != oldest.out_byte)
                        report_mismatch("out_byte", int'(m_axis_tdata),
                                        int'(oldest.out_byte));
                    if (m_axis_tuser[0] != oldest.is_length)
                        report_mismatch("is_length", int'(m_axis_tuser[0]),
                                        int'(oldest.is_length));
                    if (m_axis_tuser[1] != oldest.name_end)
                        report_mismatch("name_end", int'(m_axis_tuser[1]),
                                        int'(oldest.name_end));
                    if (m_axis_tlast != oldest.run_last)
                        report_mismatch("run_last", int'(m_axis_tlast),
                                        int'(oldest.run_last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                encode_char(s_axis_tdata);
            pending <= wire_bytes.size();
        end
    end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for the DNS name label encoder.
// ----------------------------------------------------------------------------
//
// Feeds dotted names one character per request: a short directed set of
// corner cases, a phase of full 63-character labels against a stalled
// receiver, then random names, mostly well formed with random content and
// some broken ones. Both sides idle at random. The checker beside the block
// predicts every output byte; this module only drives and gives the verdict.
//
module testbench
    import dnle_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned RANDOM_CHARS = 200;
    // longest burst: 63 reads and loads plus the length byte
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned FULL_LABEL = 63;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_data;
    logic [1:0]  m_user;
    logic        m_last;

    int unsigned pending;
    int unsigned failures;
    int unsigned cycle_count = 0;
    int unsigned chars_sent = 0;
    int unsigned hold_cycles = 0;  // long receiver hold-off asked by stimulus
    bit          calm = 1'b0;      // no idling on either side while set

    dns_name_label_encoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    dnle_checker encoder_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last),
        .pending       (pending),
        .failures      (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run; the limit covers the slowest legal run many times.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("dns_name_label_encoder regression: fail");
                $finish;
            end
        end
    end

    // Idle length: mostly none, often short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Any label character: every value but end of name and dot.
    function automatic logic [7:0] label_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == DOT_CHAR);
        return c;
    endfunction

    // Offer one character after a random gap, hold it until taken, and
    // return at the following falling edge.
    task automatic send_char(input logic [7:0] c);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_label(input int unsigned len);
        repeat (len) send_char(label_char());
    endtask

    // Stop offering until every predicted byte has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver: honor a requested hold-off first, else stall at random.
    initial
    begin
        int unsigned stall;
        m_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            else
            begin
                stall = pick_gap();
                if (stall != 0)
                begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [7:0]  directed_seq [22];
        int unsigned random_start;
        int unsigned kind;
        int unsigned labels;
        int unsigned len;
        int unsigned r;

        rst_n   = 1'b0;
        s_valid = 1'b0;
        s_data  = 8'h00;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed corner cases, one name after another.
        directed_seq = '{
            8'hFF, 8'h01, NUL_CHAR,            // label closed by end of name
            8'h61, DOT_CHAR, 8'h62, NUL_CHAR,  // dot closes a label
            DOT_CHAR, 8'h78, NUL_CHAR,         // leading dot: terminate, drop rest
            8'h61, DOT_CHAR, DOT_CHAR, 8'h71, NUL_CHAR,  // two dots in a row
            NUL_CHAR,                          // empty name
            8'h62, DOT_CHAR, NUL_CHAR,         // trailing dot
            8'h80, 8'h7F, NUL_CHAR             // opposite bit patterns
        };
        calm = 1'b1;
        foreach (directed_seq[i])
            send_char(directed_seq[i]);
        wait_drained();

        // Full labels while the receiver holds off: the block must fill up
        // and push back on its input.
        calm = 1'b0;
        hold_cycles = HOLD_OFF_CYCLES;
        send_label(FULL_LABEL);
        send_char(DOT_CHAR);            // dot right after a full label: skipped
        send_label(FULL_LABEL);
        send_char(NUL_CHAR);            // end right after a full label
        send_label(FULL_LABEL + 5);     // split label, then its tail
        send_char(DOT_CHAR);
        send_char(NUL_CHAR);
        send_label(FULL_LABEL);
        send_char(DOT_CHAR);
        send_char(DOT_CHAR);            // now an empty label
        send_char(8'h7A);
        send_char(NUL_CHAR);
        wait_drained();

        // Random names.
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 99) < 15)
                calm = !calm;
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                // well formed: a few labels of random characters
                labels = $urandom_range(1, 4);
                for (int unsigned l = 0; l < labels; l++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 85)
                        len = $urandom_range(1, 12);
                    else if (r < 95)
                        len = $urandom_range(13, 40);
                    else
                        len = $urandom_range(60, 70);
                    send_label(len);
                    if (l + 1 < labels || $urandom_range(0, 9) == 0)
                        send_char(DOT_CHAR);
                end
                send_char(NUL_CHAR);
            end
            else if (kind < 90)
            begin
                // noise: dots and ends anywhere
                len = $urandom_range(1, 12);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 25)
                        send_char(DOT_CHAR);
                    else if (r < 35)
                        send_char(NUL_CHAR);
                    else
                        send_char(label_char());
                end
                send_char(NUL_CHAR);
            end
            else
            begin
                // full label followed by a dot, a label character or the end, picked at random
                send_label(FULL_LABEL);
                r = $urandom_range(0, 3);
                if (r == 0)
                begin
                    send_char(DOT_CHAR);
                    send_label($urandom_range(1, 5));
                end
                else if (r == 1)
                begin
                    send_char(DOT_CHAR);
                    send_char(DOT_CHAR);
                end
                else if (r == 2)
                begin
                    send_label($urandom_range(1, 5));
                    send_char(DOT_CHAR);
                end
                send_char(NUL_CHAR);
            end
            if ($urandom_range(0, 99) < 5)
                wait_drained();
        end

        // Let the last bytes out, then watch for strays.
        calm = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (failures == 0 && pending == 0)
            $display("dns_name_label_encoder regression: pass");
        else
            $display("dns_name_label_encoder regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dnle_pkg.sv
hw/rtl/dnle_ram.sv
hw/rtl/dnle_out_reg.sv
hw/rtl/dns_name_label_encoder.sv
dv/dnle_checker.sv
dv/testbench.sv
